FILE: rtl/cgl_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// cgl_pkg: shared types and constants of the colour grading LUT entry block
// Fixed-point widths, register codes, the config bundle and helper functions.
// ---------------------------------------------------------------------------
package cgl_pkg;

    // default largest grid size
    localparam int MAX_GRID_DEF = 33;

    // port widths
    localparam int IDX_W      = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;
    localparam int ENTRY_W    = 16;
    localparam int COL_W      = 16;

    // internal fixed-point widths
    localparam int Q16_W   = 21;   // signed Q4.16
    localparam int GAIN_W  = 16;   // signed Q2.14
    localparam int RECIP_W = 25;   // Q0.24 reciprocal, 1.0 included
    localparam int SAT_W   = 40;   // width of the saturator input

    // number of register stages from input to result
    localparam int PIPE_DEPTH = 7;

    localparam logic signed [GAIN_W-1:0] GAIN_ONE = 16'sd16384;
    localparam logic signed [GAIN_W-1:0] GAIN_MAX = 16'sd32767;
    localparam logic signed [Q16_W-1:0]  Q16_MAX  = 21'sd1048575;
    localparam logic signed [Q16_W-1:0]  Q16_MIN  = -21'sd1048576;
    localparam logic signed [Q16_W-1:0]  Q16_HALF = 21'sd32768;

    // rounding constant of a Q2.14 product
    localparam int Q14_RND = 8192;

    // luma weights, Q0.16
    localparam logic [16:0] LUMA_WR = 17'd19595;
    localparam logic [16:0] LUMA_WG = 17'd38470;
    localparam logic [16:0] LUMA_WB = 17'd7471;

    // x / 100 as (x * DIV100_MUL) >> DIV100_SH, exact for x below 2^23 + 2^22
    localparam logic [23:0] DIV100_MUL = 24'd10737419;
    localparam int          DIV100_SH  = 30;

    // register indexes of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GRID_SIZE = 3'd0,
        CFG_RED_BAL   = 3'd1,
        CFG_BLUE_BAL  = 3'd2,
        CFG_BRIGHT    = 3'd3,
        CFG_CONTRAST  = 3'd4,
        CFG_SATUR     = 3'd5
    } t_cfg_idx;

    // derived configuration, held in registers
    typedef struct packed {
        logic        [RECIP_W-1:0] recip;
        logic signed [GAIN_W-1:0]  gain_r;
        logic signed [GAIN_W-1:0]  gain_b;
        logic signed [GAIN_W-1:0]  gain_c;
        logic signed [GAIN_W-1:0]  gain_s;
        logic signed [Q16_W-1:0]   offset;
    } t_cfg;

    // saturate to signed Q4.16
    function automatic logic signed [Q16_W-1:0] sat_q16(input logic signed [SAT_W-1:0] v);
        logic signed [Q16_W-1:0] res;
        if (v > SAT_W'(Q16_MAX)) begin
            res = Q16_MAX;
        end else if (v < SAT_W'(Q16_MIN)) begin
            res = Q16_MIN;
        end else begin
            res = Q16_W'(v);
        end
        return res;
    endfunction

    // round(2^24 / d), d = grid size minus one
    function automatic logic [RECIP_W-1:0] recip_q24(input logic [IDX_W-1:0] d);
        logic [RECIP_W-1:0] res;
        case (d)
            6'd1:    res = 25'd16777216;
            6'd2:    res = 25'd8388608;
            6'd3:    res = 25'd5592405;
            6'd4:    res = 25'd4194304;
            6'd5:    res = 25'd3355443;
            6'd6:    res = 25'd2796203;
            6'd7:    res = 25'd2396745;
            6'd8:    res = 25'd2097152;
            6'd9:    res = 25'd1864135;
            6'd10:   res = 25'd1677722;
            6'd11:   res = 25'd1525201;
            6'd12:   res = 25'd1398101;
            6'd13:   res = 25'd1290555;
            6'd14:   res = 25'd1198373;
            6'd15:   res = 25'd1118481;
            6'd16:   res = 25'd1048576;
            6'd17:   res = 25'd986895;
            6'd18:   res = 25'd932068;
            6'd19:   res = 25'd883011;
            6'd20:   res = 25'd838861;
            6'd21:   res = 25'd798915;
            6'd22:   res = 25'd762601;
            6'd23:   res = 25'd729444;
            6'd24:   res = 25'd699051;
            6'd25:   res = 25'd671089;
            6'd26:   res = 25'd645278;
            6'd27:   res = 25'd621378;
            6'd28:   res = 25'd599186;
            6'd29:   res = 25'd578525;
            6'd30:   res = 25'd559241;
            6'd31:   res = 25'd541201;
            6'd32:   res = 25'd524288;
            6'd33:   res = 25'd508400;
            6'd34:   res = 25'd493448;
            6'd35:   res = 25'd479349;
            6'd36:   res = 25'd466034;
            6'd37:   res = 25'd453438;
            6'd38:   res = 25'd441506;
            6'd39:   res = 25'd430185;
            6'd40:   res = 25'd419430;
            6'd41:   res = 25'd409200;
            6'd42:   res = 25'd399458;
            6'd43:   res = 25'd390168;
            6'd44:   res = 25'd381300;
            6'd45:   res = 25'd372827;
            6'd46:   res = 25'd364722;
            6'd47:   res = 25'd356962;
            6'd48:   res = 25'd349525;
            6'd49:   res = 25'd342392;
            6'd50:   res = 25'd335544;
            6'd51:   res = 25'd328965;
            6'd52:   res = 25'd322639;
            6'd53:   res = 25'd316551;
            6'd54:   res = 25'd310689;
            6'd55:   res = 25'd305040;
            6'd56:   res = 25'd299593;
            6'd57:   res = 25'd294337;
            6'd58:   res = 25'd289262;
            6'd59:   res = 25'd284360;
            6'd60:   res = 25'd279620;
            6'd61:   res = 25'd275036;
            6'd62:   res = 25'd270600;
            default: res = '0;
        endcase
        return res;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/cgl_cfg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// cgl_cfg: configuration registers
// Clamps the grid size and looks up its reciprocal, turns percent shifts
// into Q2.14 gains and the brightness percent into a Q4.16 offset.
// ---------------------------------------------------------------------------
module cgl_cfg #(
    parameter int  MAX_GRID = cgl_pkg::MAX_GRID_DEF,
    localparam int GRID_W   = $clog2(MAX_GRID + 1)
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [cgl_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [cgl_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output cgl_pkg::t_cfg                         o_cfg,
    output logic      [GRID_W-1:0]                o_grid
);
    import cgl_pkg::*;

    localparam int CW       = (GRID_W > IDX_W) ? GRID_W : IDX_W;
    localparam int GRID_RST = (17 > MAX_GRID) ? MAX_GRID : 17;

    t_cfg              r_cfg;
    logic [GRID_W-1:0] r_grid;

    logic signed [7:0]  s8;
    logic signed [8:0]  val9;
    logic               is_off;
    logic               neg;
    logic [7:0]         mag;
    logic [23:0]        x;
    logic [47:0]        prod;
    logic [17:0]        q;
    logic signed [18:0] r19;
    logic signed [GAIN_W-1:0] n_gain;
    logic signed [Q16_W-1:0]  n_offset;
    logic [CW-1:0]      size_in;
    logic [CW-1:0]      size_clamp;
    logic [CW-1:0]      size_m1;

    // shared divide-by-100 with rounding away from zero
    always_comb begin
        s8     = signed'(i_cfg_data);
        is_off = (t_cfg_idx'(i_cfg_idx) == CFG_BRIGHT);
        // offset: s*65536/100, gain: (100+s)*16384/100
        val9   = is_off ? 9'(s8) : (9'(s8) + 9'sd100);
        neg    = val9[8];
        mag    = 8'(neg ? -val9 : val9);
        x      = is_off ? ({mag, 16'd0} + 24'd50) : ({2'd0, mag, 14'd0} + 24'd50);
        prod   = 48'(x) * 48'(DIV100_MUL);
        q      = prod[47:DIV100_SH];
        r19    = neg ? -signed'({1'b0, q}) : signed'({1'b0, q});
        n_gain   = (r19 > 19'(GAIN_MAX)) ? GAIN_MAX : GAIN_W'(r19);
        n_offset = Q16_W'(r19);
    end

    // grid size clamp and reciprocal lookup
    always_comb begin
        size_in = CW'(i_cfg_data[IDX_W-1:0]);
        if (size_in < CW'(2)) begin
            size_clamp = CW'(2);
        end else if (size_in > CW'(MAX_GRID)) begin
            size_clamp = CW'(MAX_GRID);
        end else begin
            size_clamp = size_in;
        end
        size_m1 = size_clamp - CW'(1);
    end

    // register file; unknown indexes are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid         <= GRID_W'(GRID_RST);
            r_cfg.recip    <= recip_q24(IDX_W'(GRID_RST - 1));
            r_cfg.gain_r   <= GAIN_ONE;
            r_cfg.gain_b   <= GAIN_ONE;
            r_cfg.gain_c   <= GAIN_ONE;
            r_cfg.gain_s   <= GAIN_ONE;
            r_cfg.offset   <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_GRID_SIZE: begin
                    r_grid      <= GRID_W'(size_clamp);
                    r_cfg.recip <= recip_q24(IDX_W'(size_m1));
                end
                CFG_RED_BAL:  r_cfg.gain_r <= n_gain;
                CFG_BLUE_BAL: r_cfg.gain_b <= n_gain;
                CFG_BRIGHT:   r_cfg.offset <= n_offset;
                CFG_CONTRAST: r_cfg.gain_c <= n_gain;
                CFG_SATUR:    r_cfg.gain_s <= n_gain;
                default: ;
            endcase
        end
    end

    assign o_cfg  = r_cfg;
    assign o_grid = r_grid;

endmodule
`default_nettype wire

FILE: rtl/cgl_index.sv
`default_nettype none
// ---------------------------------------------------------------------------
// cgl_index: linear entry number
// (r*size+g)*size+b over two multiply stages, then delayed to line up with
// the colour path.
// ---------------------------------------------------------------------------
module cgl_index #(
    parameter int  MAX_GRID = cgl_pkg::MAX_GRID_DEF,
    localparam int GRID_W   = $clog2(MAX_GRID + 1)
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_en,
    input  wire logic [GRID_W-1:0]             i_grid,
    input  wire logic [cgl_pkg::IDX_W-1:0]     i_red_index,
    input  wire logic [cgl_pkg::IDX_W-1:0]     i_green_index,
    input  wire logic [cgl_pkg::IDX_W-1:0]     i_blue_index,
    output logic      [cgl_pkg::ENTRY_W-1:0]   o_entry_index
);
    import cgl_pkg::*;

    localparam int A_W  = IDX_W + GRID_W + 1;
    localparam int P_W  = A_W + GRID_W + 1;
    localparam int E_W  = (P_W > ENTRY_W) ? P_W : ENTRY_W;
    localparam int DLY  = PIPE_DEPTH - 2;

    logic [A_W-1:0]     r_row;
    logic [IDX_W-1:0]   r_blue;
    logic [ENTRY_W-1:0] r_dly [DLY+1];
    logic [E_W-1:0]     n_entry;

    always_comb begin
        n_entry = E_W'(r_row) * E_W'(i_grid) + E_W'(r_blue);
    end

    // stage one: row offset; stage two: full index; then the delay line
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_row    <= A_W'(i_red_index) * A_W'(i_grid) + A_W'(i_green_index);
            r_blue   <= i_blue_index;
            r_dly[0] <= n_entry[ENTRY_W-1:0];
            for (int k = 1; k <= DLY; k++) begin
                r_dly[k] <= r_dly[k-1];
            end
        end
    end

    assign o_entry_index = r_dly[DLY];

endmodule
`default_nettype wire

FILE: rtl/cgl_grade.sv
`default_nettype none
// ---------------------------------------------------------------------------
// cgl_grade: colour grading pipeline
// Seven stages: normalise, white balance, brightness, contrast, luma,
// saturation product, saturation sum with Q1.15 output.
// ---------------------------------------------------------------------------
module cgl_grade (
    input  wire logic                          i_clk,
    input  wire logic                          i_en,
    input  wire cgl_pkg::t_cfg                 i_cfg,
    input  wire logic [cgl_pkg::IDX_W-1:0]     i_red_index,
    input  wire logic [cgl_pkg::IDX_W-1:0]     i_green_index,
    input  wire logic [cgl_pkg::IDX_W-1:0]     i_blue_index,
    output logic      [cgl_pkg::COL_W-1:0]     o_red_out,
    output logic      [cgl_pkg::COL_W-1:0]     o_green_out,
    output logic      [cgl_pkg::COL_W-1:0]     o_blue_out
);
    import cgl_pkg::*;

    localparam int M_W = 24;   // rounded saturation term

    // stage registers, one entry per channel (red, green, blue)
    logic signed [Q16_W-1:0] r_norm [3];
    logic signed [Q16_W-1:0] r_wb   [3];
    logic signed [Q16_W-1:0] r_brt  [3];
    logic signed [Q16_W-1:0] r_con  [3];
    logic signed [Q16_W-1:0] r_lc   [3];
    logic signed [Q16_W-1:0] r_luma;
    logic signed [Q16_W-1:0] r_luma2;
    logic signed [M_W-1:0]   r_sm   [3];
    logic        [COL_W-1:0] r_out  [3];

    logic signed [Q16_W-1:0] n_norm [3];
    logic signed [Q16_W-1:0] n_wb   [3];
    logic signed [Q16_W-1:0] n_brt  [3];
    logic signed [Q16_W-1:0] n_con  [3];
    logic signed [Q16_W-1:0] n_luma;
    logic signed [M_W-1:0]   n_sm   [3];
    logic        [COL_W-1:0] n_out  [3];

    logic [IDX_W-1:0]         idx  [3];
    logic signed [GAIN_W-1:0] gwb  [3];

    assign idx[0] = i_red_index;
    assign idx[1] = i_green_index;
    assign idx[2] = i_blue_index;
    // green has no balance gain; unity gain passes it unchanged
    assign gwb[0] = i_cfg.gain_r;
    assign gwb[1] = GAIN_ONE;
    assign gwb[2] = i_cfg.gain_b;

    // normalise: (idx * recip + 2^7) >> 8, saturated
    always_comb begin
        logic [30:0] np;
        logic [22:0] ns;
        for (int k = 0; k < 3; k++) begin
            np = 31'(idx[k]) * 31'(i_cfg.recip) + 31'd128;
            ns = np[30:8];
            if (|ns[22:20]) begin
                n_norm[k] = Q16_MAX;
            end else begin
                n_norm[k] = signed'({1'b0, ns[19:0]});
            end
        end
    end

    // white balance gain
    always_comb begin
        logic signed [36:0] p;
        for (int k = 0; k < 3; k++) begin
            p        = r_norm[k] * gwb[k];
            p        = (p + 37'sd8192) >>> 14;
            n_wb[k]  = sat_q16(SAT_W'(p));
        end
    end

    // brightness offset
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_brt[k] = sat_q16(SAT_W'(r_wb[k]) + SAT_W'(i_cfg.offset));
        end
    end

    // contrast about mid grey
    always_comb begin
        logic signed [21:0] d;
        logic signed [37:0] p;
        for (int k = 0; k < 3; k++) begin
            d        = 22'(r_brt[k]) - 22'(Q16_HALF);
            p        = d * i_cfg.gain_c;
            p        = ((p + 38'(Q14_RND)) >>> 14) + 38'(Q16_HALF);
            n_con[k] = sat_q16(SAT_W'(p));
        end
    end

    // luma, rounded to nearest with ties rounded up
    always_comb begin
        logic signed [SAT_W-1:0] sum;
        sum = SAT_W'(r_con[0]) * signed'(SAT_W'(LUMA_WR))
            + SAT_W'(r_con[1]) * signed'(SAT_W'(LUMA_WG))
            + SAT_W'(r_con[2]) * signed'(SAT_W'(LUMA_WB))
            + SAT_W'(32768);
        sum    = sum >>> 16;
        n_luma = Q16_W'(sum);
    end

    // saturation: distance from luma times gain
    always_comb begin
        logic signed [21:0] d;
        logic signed [37:0] p;
        for (int k = 0; k < 3; k++) begin
            d       = 22'(r_lc[k]) - 22'(r_luma);
            p       = d * i_cfg.gain_s;
            p       = (p + 38'(Q14_RND)) >>> 14;
            n_sm[k] = M_W'(p);
        end
    end

    // add back luma, clamp to [0, 1.0] and round to Q1.15
    always_comb begin
        logic signed [Q16_W-1:0] v;
        logic [17:0]             u;
        for (int k = 0; k < 3; k++) begin
            v = sat_q16(SAT_W'(r_luma2) + SAT_W'(r_sm[k]));
            if (v < 0) begin
                u = '0;
            end else if (v > 21'sd65536) begin
                u = 18'd65536;
            end else begin
                u = 18'(v);
            end
            u        = (u + 18'd1) >> 1;
            n_out[k] = COL_W'(u);
        end
    end

    // stage registers
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_norm  <= n_norm;
            r_wb    <= n_wb;
            r_brt   <= n_brt;
            r_con   <= n_con;
            r_lc    <= r_con;
            r_luma  <= n_luma;
            r_sm    <= n_sm;
            r_luma2 <= r_luma;
            r_out   <= n_out;
        end
    end

    assign o_red_out   = r_out[0];
    assign o_green_out = r_out[1];
    assign o_blue_out  = r_out[2];

endmodule
`default_nettype wire

FILE: rtl/color_grade_lut_entry.sv
`default_nettype none
// ---------------------------------------------------------------------------
// color_grade_lut_entry: graded colour of one 3D LUT grid point
// Takes a grid coordinate and gives its linear entry number and the colour
// after white balance, brightness, contrast and saturation.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel: i_in_valid with the three grid indexes; an item is taken
//   at a clock edge with i_in_valid high and o_in_stall low.
//   Output channel: o_out_valid with the entry number and Q1.15 colour;
//   taken at an edge with o_out_valid high and i_out_stall low.
//   Configuration: i_cfg_we writes register i_cfg_idx with i_cfg_data;
//   write only while no item is in flight.
//   Pipeline: seven register stages, the first loaded at the accepting
//   edge; one item is taken every cycle unless the pipeline is stalled.
//   When the receiver stalls with a result waiting, the whole pipeline
//   holds and o_in_stall rises in the same cycle; nothing is dropped.
//   Reset clears all valid bits and loads the register defaults: grid size
//   17 (or the maximum if smaller), unity gains and zero offset.
// ---------------------------------------------------------------------------
module color_grade_lut_entry #(
    parameter int  MAX_GRID = cgl_pkg::MAX_GRID_DEF,
    localparam int GRID_W   = $clog2(MAX_GRID + 1)
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // configuration
    input  wire logic                            i_cfg_we,
    input  wire logic [cgl_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [cgl_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // input items
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire logic [cgl_pkg::IDX_W-1:0]       i_red_index,
    input  wire logic [cgl_pkg::IDX_W-1:0]       i_green_index,
    input  wire logic [cgl_pkg::IDX_W-1:0]       i_blue_index,
    // result items
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output logic      [cgl_pkg::ENTRY_W-1:0]     o_entry_index,
    output logic      [cgl_pkg::COL_W-1:0]       o_red_out,
    output logic      [cgl_pkg::COL_W-1:0]       o_green_out,
    output logic      [cgl_pkg::COL_W-1:0]       o_blue_out
);
    import cgl_pkg::*;

    t_cfg              cfg;
    logic [GRID_W-1:0] grid;
    logic [PIPE_DEPTH-1:0] r_vld;
    logic              adv;

    // pipeline moves unless a result waits on a stalled receiver
    assign adv        = !(r_vld[PIPE_DEPTH-1] && i_out_stall);
    assign o_in_stall = !adv;
    assign o_out_valid = r_vld[PIPE_DEPTH-1];

    // valid bits travel alongside the stage registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[PIPE_DEPTH-2:0], i_in_valid};
        end
    end

    cgl_cfg #(
        .MAX_GRID (MAX_GRID)
    ) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg),
        .o_grid     (grid)
    );

    cgl_index #(
        .MAX_GRID (MAX_GRID)
    ) u_index (
        .i_clk         (i_clk),
        .i_en          (adv),
        .i_grid        (grid),
        .i_red_index   (i_red_index),
        .i_green_index (i_green_index),
        .i_blue_index  (i_blue_index),
        .o_entry_index (o_entry_index)
    );

    cgl_grade u_grade (
        .i_clk         (i_clk),
        .i_en          (adv),
        .i_cfg         (cfg),
        .i_red_index   (i_red_index),
        .i_green_index (i_green_index),
        .i_blue_index  (i_blue_index),
        .o_red_out     (o_red_out),
        .o_green_out   (o_green_out),
        .o_blue_out    (o_blue_out)
    );

endmodule
`default_nettype wire
